// ===== hw/rtl/ris_pkg.sv =====
// Shared types and constants for the rotation source-address generator.
// Used by ris_geom, ris_map and rotate_image_source_address; no dependencies.

package ris_pkg;

	// Field and register widths.
	localparam int TRIG_W    = 16;
	localparam int TRIG_FRAC = 14;
	localparam int DIM_W     = 12;
	localparam int DEST_W    = 12;
	localparam int SRC_W     = 11;
	localparam int IDX_W     = 22;
	localparam int BOX_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Internal arithmetic widths.
	localparam int CPROD_W = DIM_W + 1 + TRIG_W;      // corner product, signed
	localparam int COORD_W = CPROD_W + 1;             // corner sums and box bounds
	localparam int PROD_W  = COORD_W + TRIG_W;        // mapping product, signed
	localparam int SUM_W   = PROD_W + 1;              // mapping sum, signed
	localparam int QUO_W   = SUM_W - 2 * TRIG_FRAC;   // truncated source coordinate

	// Source size limit and box size saturation.
	localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(2048);
	localparam logic [BOX_W-1:0] BOX_MAX = BOX_W'(8191);

	// Cycles that in_ready stays low after reset or a register write.
	localparam int               SETTLE_W      = 2;
	localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(3);

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_COS        = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SIN        = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(3);

	// Reset values of the registers.
	localparam logic [TRIG_W-1:0] COS_RESET    = TRIG_W'(16384);
	localparam logic [TRIG_W-1:0] SIN_RESET    = TRIG_W'(0);
	localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(400);

	// Geometry derived from the registers: box minima (two's complement, Q.14)
	// and the rotated box size.
	typedef struct packed {
		logic [COORD_W-1:0] minx;
		logic [COORD_W-1:0] miny;
		logic [BOX_W-1:0]   dest_width;
		logic [BOX_W-1:0]   dest_height;
	} ris_geom_t;

	// Load enables of the four mapping stages.
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} ris_stage_en_t;

endpackage

// ===== hw/rtl/ris_geom.sv =====
// Rotated bounding box: corner products, box minima and maxima, box size.
// Depends on ris_pkg. Three register stages refresh every cycle from the registers.

module ris_geom (
	input  logic                              clk,
	input  logic signed [ris_pkg::TRIG_W-1:0] cos_q14,
	input  logic signed [ris_pkg::TRIG_W-1:0] sin_q14,
	input  logic        [ris_pkg::DIM_W-1:0]  w_eff,
	input  logic        [ris_pkg::DIM_W-1:0]  h_eff,
	output ris_pkg::ris_geom_t                geom
);

	logic signed [ris_pkg::CPROD_W-1:0] wc_q, ws_q, hc_q, hs_q;
	logic signed [ris_pkg::COORD_W-1:0] p1x, p2x, p3x, p1y, p2y, p3y;
	logic signed [ris_pkg::COORD_W-1:0] minx_c, miny_c, maxx_c, maxy_c;
	logic signed [ris_pkg::COORD_W-1:0] minx_q, miny_q, maxx_q, maxy_q;
	logic        [ris_pkg::COORD_W-1:0] dx, dy, cx, cy;
	logic        [ris_pkg::COORD_W-ris_pkg::TRIG_FRAC-1:0] nx, ny;
	logic        [ris_pkg::BOX_W-1:0]   dest_width_q, dest_height_q;

	// Corner products of the source size with cosine and sine.
	always_ff @(posedge clk) begin
		wc_q <= $signed({1'b0, w_eff}) * cos_q14;
		ws_q <= $signed({1'b0, w_eff}) * sin_q14;
		hc_q <= $signed({1'b0, h_eff}) * cos_q14;
		hs_q <= $signed({1'b0, h_eff}) * sin_q14;
	end

	// Rotated corners; the origin corner stays at zero.
	always_comb begin
		p1x = -ris_pkg::COORD_W'(hs_q);
		p2x = ris_pkg::COORD_W'(wc_q) - ris_pkg::COORD_W'(hs_q);
		p3x = ris_pkg::COORD_W'(wc_q);
		p1y = ris_pkg::COORD_W'(hc_q);
		p2y = ris_pkg::COORD_W'(hc_q) + ris_pkg::COORD_W'(ws_q);
		p3y = ris_pkg::COORD_W'(ws_q);

		minx_c = (p1x < p2x) ? p1x : p2x;
		minx_c = (p3x < minx_c) ? p3x : minx_c;
		minx_c = (minx_c < 0) ? minx_c : '0;
		miny_c = (p1y < p2y) ? p1y : p2y;
		miny_c = (p3y < miny_c) ? p3y : miny_c;
		miny_c = (miny_c < 0) ? miny_c : '0;

		maxx_c = (p1x > p2x) ? p1x : p2x;
		maxx_c = (p3x > maxx_c) ? p3x : maxx_c;
		maxy_c = (p1y > p2y) ? p1y : p2y;
		maxy_c = (p3y > maxy_c) ? p3y : maxy_c;
	end

	always_ff @(posedge clk) begin
		minx_q <= minx_c;
		miny_q <= miny_c;
		maxx_q <= maxx_c;
		maxy_q <= maxy_c;
	end

	// Box size is the ceiling of the span in whole pixels, saturated.
	// The minimum includes every corner, so the span is never negative.
	always_comb begin
		dx = maxx_q - minx_q;
		dy = maxy_q - miny_q;
		cx = dx + ris_pkg::COORD_W'((1 << ris_pkg::TRIG_FRAC) - 1);
		cy = dy + ris_pkg::COORD_W'((1 << ris_pkg::TRIG_FRAC) - 1);
		nx = cx[ris_pkg::COORD_W-1:ris_pkg::TRIG_FRAC];
		ny = cy[ris_pkg::COORD_W-1:ris_pkg::TRIG_FRAC];
	end

	always_ff @(posedge clk) begin
		if (nx > (ris_pkg::COORD_W-ris_pkg::TRIG_FRAC)'(ris_pkg::BOX_MAX)) begin
			dest_width_q <= ris_pkg::BOX_MAX;
		end else begin
			dest_width_q <= nx[ris_pkg::BOX_W-1:0];
		end
		if (ny > (ris_pkg::COORD_W-ris_pkg::TRIG_FRAC)'(ris_pkg::BOX_MAX)) begin
			dest_height_q <= ris_pkg::BOX_MAX;
		end else begin
			dest_height_q <= ny[ris_pkg::BOX_W-1:0];
		end
	end

	assign geom.minx        = minx_q;
	assign geom.miny        = miny_q;
	assign geom.dest_width  = dest_width_q;
	assign geom.dest_height = dest_height_q;

endmodule

// ===== hw/rtl/ris_map.sv =====
// Four-stage inverse mapping of a destination pixel to a source address.
// Depends on ris_pkg. Stage loads come from the handshake control in the top level.

module ris_map (
	input  logic                              clk,
	input  ris_pkg::ris_stage_en_t            en,
	input  logic        [ris_pkg::DEST_W-1:0] dest_x,
	input  logic        [ris_pkg::DEST_W-1:0] dest_y,
	input  ris_pkg::ris_geom_t                geom,
	input  logic signed [ris_pkg::TRIG_W-1:0] cos_q14,
	input  logic signed [ris_pkg::TRIG_W-1:0] sin_q14,
	input  logic        [ris_pkg::DIM_W-1:0]  w_eff,
	input  logic        [ris_pkg::DIM_W-1:0]  h_eff,
	output logic        [ris_pkg::SRC_W-1:0]  src_x,
	output logic        [ris_pkg::SRC_W-1:0]  src_y,
	output logic        [ris_pkg::IDX_W-1:0]  src_index,
	output logic                              inside_res
);

	localparam int PAD_W = ris_pkg::COORD_W - ris_pkg::DEST_W - ris_pkg::TRIG_FRAC;
	localparam int SHIFT = 2 * ris_pkg::TRIG_FRAC;
	localparam int MAC_W = ris_pkg::SRC_W + ris_pkg::DIM_W;

	logic signed [ris_pkg::COORD_W-1:0] ax_s1, ay_s1;
	logic signed [ris_pkg::PROD_W-1:0]  axc_s2, axs_s2, ayc_s2, ays_s2;
	logic signed [ris_pkg::SUM_W-1:0]   sum_x, sum_y;
	logic signed [ris_pkg::QUO_W-1:0]   qx, qy;
	logic                               in_x, in_y, in_src;
	logic        [ris_pkg::SRC_W-1:0]   sx_s3, sy_s3;
	logic                               inside_s3;
	logic        [MAC_W-1:0]            index_full;
	logic        [ris_pkg::SRC_W-1:0]   sx_s4, sy_s4;
	logic        [ris_pkg::IDX_W-1:0]   index_s4;
	logic                               inside_s4;

	// Stage 1: destination pixel in Q.14, shifted by the box minima.
	always_ff @(posedge clk) begin
		if (en.ld_s1) begin
			ax_s1 <= $signed({{PAD_W{1'b0}}, dest_x, {ris_pkg::TRIG_FRAC{1'b0}}})
				+ $signed(geom.minx);
			ay_s1 <= $signed({{PAD_W{1'b0}}, dest_y, {ris_pkg::TRIG_FRAC{1'b0}}})
				+ $signed(geom.miny);
		end
	end

	// Stage 2: the four rotation products, exact in Q.28.
	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			axc_s2 <= ax_s1 * cos_q14;
			axs_s2 <= ax_s1 * sin_q14;
			ayc_s2 <= ay_s1 * cos_q14;
			ays_s2 <= ay_s1 * sin_q14;
		end
	end

	// Stage 3: sums truncated toward zero, then the bounds check.
	always_comb begin
		sum_x = ris_pkg::SUM_W'(axc_s2) + ris_pkg::SUM_W'(ays_s2);
		sum_y = ris_pkg::SUM_W'(ayc_s2) - ris_pkg::SUM_W'(axs_s2);
		qx = $signed(sum_x[ris_pkg::SUM_W-1:SHIFT])
			+ $signed({{(ris_pkg::QUO_W-1){1'b0}},
				sum_x[ris_pkg::SUM_W-1] & (|sum_x[SHIFT-1:0])});
		qy = $signed(sum_y[ris_pkg::SUM_W-1:SHIFT])
			+ $signed({{(ris_pkg::QUO_W-1){1'b0}},
				sum_y[ris_pkg::SUM_W-1] & (|sum_y[SHIFT-1:0])});
		in_x = !qx[ris_pkg::QUO_W-1]
			&& (qx[ris_pkg::QUO_W-2:0] < (ris_pkg::QUO_W-1)'(w_eff));
		in_y = !qy[ris_pkg::QUO_W-1]
			&& (qy[ris_pkg::QUO_W-2:0] < (ris_pkg::QUO_W-1)'(h_eff));
		in_src = in_x && in_y;
	end

	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			inside_s3 <= in_src;
			sx_s3     <= in_src ? qx[ris_pkg::SRC_W-1:0] : '0;
			sy_s3     <= in_src ? qy[ris_pkg::SRC_W-1:0] : '0;
		end
	end

	// Stage 4: row-major index; an outside pixel carries zeros and gives zero.
	assign index_full = sy_s3 * w_eff + MAC_W'(sx_s3);

	always_ff @(posedge clk) begin
		if (en.ld_s4) begin
			sx_s4     <= sx_s3;
			sy_s4     <= sy_s3;
			index_s4  <= index_full[ris_pkg::IDX_W-1:0];
			inside_s4 <= inside_s3;
		end
	end

	assign src_x      = sx_s4;
	assign src_y      = sy_s4;
	assign src_index  = index_s4;
	assign inside_res = inside_s4;

endmodule

// ===== hw/rtl/rotate_image_source_address.sv =====
// Top level of the rotation source-address generator: registers, handshake, stages.
// Depends on ris_pkg, ris_geom and ris_map.
//
//   channel  handshake             payload
//   cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//   in       in_valid/in_ready     dest_x, dest_y
//   out      out_valid/out_ready   src_x, src_y, src_index, inside_res,
//                                  dest_width, dest_height
//
// One beat is accepted per cycle while in_ready is high; results leave from stage 4.
// The four mapping stages advance independently, so bubbles close up while the
// output is stalled; apart from the settling below, in_ready drops only when every
// stage holds a beat and out_ready is low. After reset and after each register write,
// in_ready stays low while the three geometry register stages in ris_geom refresh.
// cfg_ready is always high.

module rotate_image_source_address (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ris_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ris_pkg::CFG_DAT_W-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ris_pkg::DEST_W-1:0]          dest_x,
	input  logic [ris_pkg::DEST_W-1:0]          dest_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ris_pkg::SRC_W-1:0]           src_x,
	output logic [ris_pkg::SRC_W-1:0]           src_y,
	output logic [ris_pkg::IDX_W-1:0]           src_index,
	output logic                                inside_res,
	output logic [ris_pkg::BOX_W-1:0]           dest_width,
	output logic [ris_pkg::BOX_W-1:0]           dest_height
);

	logic [ris_pkg::TRIG_W-1:0]   cos_q, sin_q;
	logic [ris_pkg::DIM_W-1:0]    width_q, height_q;
	logic [ris_pkg::DIM_W-1:0]    w_eff, h_eff;
	logic [ris_pkg::SETTLE_W-1:0] settle_q;
	logic                         cfg_wr;
	logic                         v_s1, v_s2, v_s3, v_s4;
	ris_pkg::ris_stage_en_t       en;
	ris_pkg::ris_geom_t           geom;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= ris_pkg::COS_RESET;
			sin_q    <= ris_pkg::SIN_RESET;
			width_q  <= ris_pkg::WIDTH_RESET;
			height_q <= ris_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				ris_pkg::REG_COS:        cos_q    <= cfg_data;
				ris_pkg::REG_SIN:        sin_q    <= cfg_data;
				ris_pkg::REG_SRC_WIDTH:  width_q  <= cfg_data[ris_pkg::DIM_W-1:0];
				ris_pkg::REG_SRC_HEIGHT: height_q <= cfg_data[ris_pkg::DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sizes above the limit are used as the limit.
	assign w_eff = (width_q > ris_pkg::MAX_DIM) ? ris_pkg::MAX_DIM : width_q;
	assign h_eff = (height_q > ris_pkg::MAX_DIM) ? ris_pkg::MAX_DIM : height_q;

	// Hold off input beats until the derived geometry matches the registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= ris_pkg::SETTLE_CYCLES;
		end else if (cfg_wr) begin
			settle_q <= ris_pkg::SETTLE_CYCLES;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	// A stage loads when it is empty or its beat moves on.
	always_comb begin
		en.ld_s4 = !v_s4 || out_ready;
		en.ld_s3 = !v_s3 || en.ld_s4;
		en.ld_s2 = !v_s2 || en.ld_s3;
		en.ld_s1 = !v_s1 || en.ld_s2;
	end

	assign in_ready  = en.ld_s1 && (settle_q == '0);
	assign out_valid = v_s4;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.ld_s1) begin
				v_s1 <= in_valid && in_ready;
			end
			if (en.ld_s2) begin
				v_s2 <= v_s1;
			end
			if (en.ld_s3) begin
				v_s3 <= v_s2;
			end
			if (en.ld_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	ris_geom u_geom (
		.clk     (clk),
		.cos_q14 ($signed(cos_q)),
		.sin_q14 ($signed(sin_q)),
		.w_eff   (w_eff),
		.h_eff   (h_eff),
		.geom    (geom)
	);

	ris_map u_map (
		.clk        (clk),
		.en         (en),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.geom       (geom),
		.cos_q14    ($signed(cos_q)),
		.sin_q14    ($signed(sin_q)),
		.w_eff      (w_eff),
		.h_eff      (h_eff),
		.src_x      (src_x),
		.src_y      (src_y),
		.src_index  (src_index),
		.inside_res (inside_res)
	);

	assign dest_width  = geom.dest_width;
	assign dest_height = geom.dest_height;

`ifndef ASSERT_OFF
	// A register write must block input beats on the following cycle.
	a_settle_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !in_ready)
		else $error("input accepted right after a register write");

	// An outside pixel gives an all-zero address.
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !inside_res |-> src_x == '0 && src_y == '0 && src_index == '0)
		else $error("outside pixel with nonzero address");

	// An inside pixel lies within the clamped source size.
	a_inside_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inside_res |->
			ris_pkg::DIM_W'(src_x) < w_eff && ris_pkg::DIM_W'(src_y) < h_eff)
		else $error("inside pixel beyond the source size");
`endif

endmodule
